// ----- rtl/pbm_pkg.sv -----
`timescale 1ns / 1ps

package pbm_pkg;

  // Number of colour lanes (blue, green, red); alpha is carried beside them and joined in the merge stage.
  localparam int unsigned NumLanes = 3;

  // Blend mode codes as held in the blend_mode register.
  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_ADD      = 3'd3,
    MODE_OVERLAY  = 3'd4
  } blend_mode_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_BLEND_MODE = 1'b0,
    CFG_OPACITY    = 1'b1
  } cfg_reg_e;

  // Input transaction: destination and source pixel.
  typedef struct packed {
    logic [7:0] dst_blue;
    logic [7:0] dst_green;
    logic [7:0] dst_red;
    logic [7:0] dst_alpha;
    logic [7:0] src_blue;
    logic [7:0] src_green;
    logic [7:0] src_red;
    logic [7:0] src_alpha;
  } pbm_in_t;

  // Output transaction: composited pixel.
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } pbm_out_t;

  // Load enables for the three lane pipeline registers.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pbm_stage_en_t;

  // Rounded division by 255: (x + 127) / 255, exact for x + 127 below 65535.
  // The floor by 255 is done as (y + (y >> 8) + 1) >> 8.
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [17:0] y;
    logic [17:0] t;
    y = {1'b0, x} + 18'd127;
    t = y + (y >> 8) + 18'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/pixel_blend_mode_compositor.sv -----
`timescale 1ns / 1ps
// Pixel blend-mode compositor.
// The input channel takes one transaction per pixel: a destination (background)
// and a source (layer) BGRA pixel. The output channel returns one composited
// BGRA pixel per input transaction, in order. Both channels use valid/ready.
// The configuration channel writes blend_mode (index 0) and opacity (index 1);
// it is always ready, and writes are only to be made while no pixel is in flight.
// From input acceptance to output valid a pixel passes the mode multiply,
// blend selection, opacity multiplies, then the rounding sum into the output
// register. Blue, green and red each run in their own lane; while the receiver
// keeps up, a new pixel can be accepted each cycle; throughput is one pixel per clock.
// Each pipeline stage has its own valid bit and takes a new pixel whenever it is
// empty or the stage after it moves on, so a stalled receiver holds the result in
// the output register while up to three further pixels enter behind it; input
// ready falls only when all four stages are occupied and the receiver stalls.
// Reset empties the pipeline, sets blend_mode to normal and opacity to 255.
module pixel_blend_mode_compositor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbm_pkg::pbm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbm_pkg::pbm_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import pbm_pkg::*;

  logic [2:0] mode_q;
  logic [7:0] opacity_q;
  logic       v1_q, v2_q, v3_q, v4_q;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic       mode_bad;
  logic       pass_thru;
  logic       copy_src;
  logic [7:0] lane_opacity;
  logic [7:0] alpha_d;
  logic [7:0] a1_q, a2_q, a3_q;
  pbm_stage_en_t stage_en;
  logic [NumLanes-1:0][7:0] lane_dst;
  logic [NumLanes-1:0][7:0] lane_src;
  logic [NumLanes-1:0][7:0] lane_res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      opacity_q <= 8'hFF;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BLEND_MODE: mode_q    <= cfg_data_i[2:0];
        CFG_OPACITY:    opacity_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when its successor moves.
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

  assign stage_en.s1 = rdy1;
  assign stage_en.s2 = rdy2;
  assign stage_en.s3 = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Special cases. An unused mode code behaves as zero opacity, so the lanes
  // return the destination colour unchanged.
  assign mode_bad     = mode_q > MODE_OVERLAY;
  assign pass_thru    = (opacity_q == 8'd0) || mode_bad;
  assign copy_src     = (mode_q == MODE_NORMAL) && (opacity_q == 8'hFF);
  assign lane_opacity = mode_bad ? 8'd0 : opacity_q;

  always_comb begin
    if (pass_thru) begin
      alpha_d = in_data_i.dst_alpha;
    end else if (copy_src) begin
      alpha_d = in_data_i.src_alpha;
    end else begin
      alpha_d = 8'hFF;
    end
  end

  // Alpha travels alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (rdy1) a1_q <= alpha_d;
    if (rdy2) a2_q <= a1_q;
    if (rdy3) a3_q <= a2_q;
  end

  // Colour lanes.
  assign lane_dst[0] = in_data_i.dst_blue;
  assign lane_dst[1] = in_data_i.dst_green;
  assign lane_dst[2] = in_data_i.dst_red;
  assign lane_src[0] = in_data_i.src_blue;
  assign lane_src[1] = in_data_i.src_green;
  assign lane_src[2] = in_data_i.src_red;

  for (genvar g = 0; g < NumLanes; g++) begin : gen_lane
    pbm_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (stage_en),
      .mode_i    (mode_q),
      .opacity_i (lane_opacity),
      .dst_i     (lane_dst[g]),
      .src_i     (lane_src[g]),
      .res_o     (lane_res[g])
    );
  end

  // Merge lanes and alpha into the output register.
  pbm_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (rdy4),
    .lane_res_i (lane_res),
    .alpha_i    (a3_q),
    .data_o     (out_data_o)
  );

  // A full pipeline with a stalled receiver must refuse input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while the pipeline is full and stalled");

  // An accepted transaction occupies the first stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted transaction lost at the first stage");

  // A finished pixel moving into the output register shows as valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> out_valid_o)
    else $error("pixel from the last lane stage did not reach the output");

  // A delivered pixel with nothing behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !v3_q) |=> !out_valid_o)
    else $error("output pixel repeated after delivery");

endmodule

// ----- rtl/pbm_lane.sv -----
`timescale 1ns / 1ps

module pbm_lane (
  input  logic                   clk_i,
  input  pbm_pkg::pbm_stage_en_t en_i,
  input  logic [2:0]             mode_i,
  input  logic [7:0]             opacity_i,
  input  logic [7:0]             dst_i,
  input  logic [7:0]             src_i,
  output logic [7:0]             res_o
);
  import pbm_pkg::*;

  logic [8:0]  op_a;
  logic [7:0]  op_b;
  logic [16:0] prod_q;
  logic [7:0]  d1_q;
  logic [7:0]  s1_q;
  logic [7:0]  q2;
  logic [8:0]  sum2;
  logic [7:0]  blend_d;
  logic [7:0]  b2_q;
  logic [7:0]  d2_q;
  logic [7:0]  inv_opacity;
  logic [15:0] pd_q;
  logic [15:0] pb_q;
  logic [16:0] mix_sum;

  // Operand selection for the single mode multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (mode_i)
      MODE_MULTIPLY: begin
        op_a = {1'b0, dst_i};
        op_b = src_i;
      end
      MODE_SCREEN: begin
        op_a = {1'b0, ~dst_i};
        op_b = ~src_i;
      end
      MODE_OVERLAY: begin
        // Dark base doubles the product; light base doubles the inverse product.
        if (!dst_i[7]) begin
          op_a = {dst_i, 1'b0};
          op_b = src_i;
        end else begin
          op_a = {~dst_i, 1'b0};
          op_b = ~src_i;
        end
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Stage 1: mode product.
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_q <= op_a * op_b;
      d1_q   <= dst_i;
      s1_q   <= src_i;
    end
  end

  // Stage 2: scale the product back to 8 bits and pick the blended value.
  assign q2   = div255(prod_q);
  assign sum2 = {1'b0, d1_q} + {1'b0, s1_q};

  always_comb begin
    case (mode_i)
      MODE_MULTIPLY: blend_d = q2;
      MODE_SCREEN:   blend_d = ~q2;
      MODE_ADD:      blend_d = sum2[8] ? 8'hFF : sum2[7:0];
      MODE_OVERLAY:  blend_d = d1_q[7] ? ~q2 : q2;
      default:       blend_d = s1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      b2_q <= blend_d;
      d2_q <= d1_q;
    end
  end

  // Stage 3: opacity weighting of destination and blended value.
  assign inv_opacity = ~opacity_i;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      pd_q <= d2_q * inv_opacity;
      pb_q <= b2_q * opacity_i;
    end
  end

  // Final sum and rounding, registered in the merge stage.
  assign mix_sum = {1'b0, pd_q} + {1'b0, pb_q};
  assign res_o   = div255(mix_sum);

endmodule

// ----- rtl/pbm_merge.sv -----
`timescale 1ns / 1ps

module pbm_merge (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [pbm_pkg::NumLanes-1:0][7:0]     lane_res_i,
  input  logic [7:0]                            alpha_i,
  output pbm_pkg::pbm_out_t                     data_o
);
  import pbm_pkg::*;

  pbm_out_t data_d;
  pbm_out_t data_q;

  // Assemble the pixel from the colour lanes and the carried alpha.
  always_comb begin
    data_d.out_blue  = lane_res_i[0];
    data_d.out_green = lane_res_i[1];
    data_d.out_red   = lane_res_i[2];
    data_d.out_alpha = alpha_i;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
